[design/escape_sequence_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the escape sequence decoder
// Clocked implication checks, held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication
`define ESD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape decoder check failed");

// Next-cycle implication
`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape decoder check failed");

`endif

[design/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// Types and character codes shared by the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX0  = 3'd2,
        MODE_HEX1  = 3'd3,
        MODE_OCT   = 3'd4,
        MODE_DONE  = 3'd5
    } t_mode;

    // Input request
    typedef struct packed {
        logic [7:0] in_char;
        logic       is_end;
    } t_esd_in;

    // Result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_esd_out;

    // Per-string parser state
    typedef struct packed {
        t_mode       mode;
        logic [8:0]  accum;
        logic [1:0]  count;
        logic [15:0] emitted;
    } t_esd_state;

    // Results produced by one input request, in order
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] data0;
        logic [7:0] data1;
    } t_esd_push;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D7   = 8'h37;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LN   = 8'h6E;
    localparam logic [7:0] CH_LR   = 8'h72;
    localparam logic [7:0] CH_LT   = 8'h74;
    localparam logic [7:0] CH_LV   = 8'h76;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_QM   = 8'h3F;

    localparam logic [7:0] ESC_BEL = 8'h07;
    localparam logic [7:0] ESC_BS  = 8'h08;
    localparam logic [7:0] ESC_FF  = 8'h0C;
    localparam logic [7:0] ESC_LF  = 8'h0A;
    localparam logic [7:0] ESC_CR  = 8'h0D;
    localparam logic [7:0] ESC_HT  = 8'h09;
    localparam logic [7:0] ESC_VT  = 8'h0B;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

endpackage

[design/esd_decode.sv]
// ----------------------------------------------------------------------------
// esd_decode
// Next-state and result logic for one source character.
// ----------------------------------------------------------------------------
module esd_decode
    import esd_pkg::*;
(
    input  t_esd_state  i_state,
    input  t_esd_in     i_item,
    input  logic [15:0] i_limit,
    output t_esd_state  o_next,
    output t_esd_push   o_push
);

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= CH_D0 && c <= CH_D9) begin
            t = c - CH_D0;
            return {1'b1, t[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + 8'd10;
            return {1'b1, t[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            t = c - CH_LA + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    // {valid, byte} of a simple escape letter
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            CH_LA:   r = {1'b1, ESC_BEL};
            CH_LB:   r = {1'b1, ESC_BS};
            CH_LF:   r = {1'b1, ESC_FF};
            CH_LN:   r = {1'b1, ESC_LF};
            CH_LR:   r = {1'b1, ESC_CR};
            CH_LT:   r = {1'b1, ESC_HT};
            CH_LV:   r = {1'b1, ESC_VT};
            CH_SQ:   r = {1'b1, CH_SQ};
            CH_DQ:   r = {1'b1, CH_DQ};
            CH_BSL:  r = {1'b1, CH_BSL};
            CH_QM:   r = {1'b1, CH_QM};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // {valid, byte} left behind by a pending escape
    function automatic logic [8:0] flush_of(input t_mode md, input logic [8:0] acc);
        logic [8:0] r;
        unique case (md)
            MODE_HEX0:          r = {1'b1, 8'h00};
            MODE_HEX1, MODE_OCT: r = {1'b1, acc[7:0]};
            default:            r = 9'd0;
        endcase
        return r;
    endfunction

    logic [7:0]  c;
    logic        is_oct;
    logic [4:0]  hex;
    logic [8:0]  simp;
    logic [8:0]  fl_pre;
    logic [8:0]  fl_end;
    logic [8:0]  oct_acc;
    logic [1:0]  oct_cnt;
    t_mode       m1;
    logic [8:0]  a1;
    logic [1:0]  n1;
    logic        v0, v1, w0, w1;
    logic [7:0]  b0, b1, x0, x1;
    logic        clear_str;
    logic        g0, g1;
    logic [15:0] e1, e2;

    assign c       = i_item.in_char;
    assign is_oct  = (c >= CH_D0) && (c <= CH_D7);
    assign hex     = hex_digit(c);
    assign simp    = simple_esc(c);
    assign fl_pre  = flush_of(i_state.mode, i_state.accum);
    assign oct_acc = {i_state.accum[5:0], c[2:0]};
    assign oct_cnt = i_state.count + 2'd1;

    // Character decode, then flush at end of string
    always_comb begin
        m1        = i_state.mode;
        a1        = i_state.accum;
        n1        = i_state.count;
        v0        = 1'b0;
        b0        = 8'h00;
        v1        = 1'b0;
        b1        = 8'h00;
        clear_str = 1'b0;
        fl_end    = 9'd0;

        if (i_state.mode == MODE_DONE) begin
            clear_str = i_item.is_end;
        end else if (c == CH_NUL) begin
            v0 = fl_pre[8];
            b0 = fl_pre[7:0];
            if (i_item.is_end) begin
                clear_str = 1'b1;
            end else begin
                m1 = MODE_DONE;
                a1 = 9'd0;
                n1 = 2'd0;
            end
        end else begin
            unique case (i_state.mode)
                MODE_ESC: begin
                    m1 = MODE_PLAIN;
                    if (simp[8]) begin
                        v0 = 1'b1;
                        b0 = simp[7:0];
                    end else if (c == CH_X) begin
                        m1 = MODE_HEX0;
                        a1 = 9'd0;
                    end else if (is_oct) begin
                        m1 = MODE_OCT;
                        a1 = {6'd0, c[2:0]};
                        n1 = 2'd1;
                    end else begin
                        v0 = 1'b1;
                        b0 = c;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_OCT: begin
                    if (i_state.mode == MODE_HEX0 && hex[4]) begin
                        m1 = MODE_HEX1;
                        a1 = {5'd0, hex[3:0]};
                    end else if (i_state.mode == MODE_HEX1 && hex[4]) begin
                        v0 = 1'b1;
                        b0 = {i_state.accum[3:0], hex[3:0]};
                        m1 = MODE_PLAIN;
                        a1 = 9'd0;
                    end else if (i_state.mode == MODE_OCT && is_oct) begin
                        if (oct_cnt == 2'd3 || oct_cnt == 2'd0) begin
                            v0 = 1'b1;
                            b0 = oct_acc[7:0];
                            m1 = MODE_PLAIN;
                            a1 = 9'd0;
                            n1 = 2'd0;
                        end else begin
                            a1 = oct_acc;
                            n1 = oct_cnt;
                        end
                    end else begin
                        // digit run broken: pending value, then the character as text or a new escape
                        v0 = fl_pre[8];
                        b0 = fl_pre[7:0];
                        a1 = 9'd0;
                        n1 = 2'd0;
                        m1 = (c == CH_BSL) ? MODE_ESC : MODE_PLAIN;
                        v1 = (c != CH_BSL);
                        b1 = c;
                    end
                end
                default: begin
                    m1 = (c == CH_BSL) ? MODE_ESC : MODE_PLAIN;
                    v0 = (c != CH_BSL);
                    b0 = c;
                end
            endcase
            if (i_item.is_end) begin
                fl_end    = flush_of(m1, a1);
                clear_str = 1'b1;
            end
        end
    end

    // Append the end flush behind any decoded bytes
    always_comb begin
        w0 = v0 | fl_end[8];
        x0 = v0 ? b0 : fl_end[7:0];
        w1 = v1 | (v0 & fl_end[8]);
        x1 = v1 ? b1 : fl_end[7:0];
    end

    // Output limit
    assign g0 = w0 && (i_state.emitted < i_limit);
    assign e1 = i_state.emitted + {15'd0, g0};
    assign g1 = w1 && (e1 < i_limit);
    assign e2 = e1 + {15'd0, g1};

    always_comb begin
        o_next.mode    = clear_str ? MODE_PLAIN : m1;
        o_next.accum   = clear_str ? 9'd0 : a1;
        o_next.count   = clear_str ? 2'd0 : n1;
        o_next.emitted = clear_str ? 16'd0 : e2;
        o_push.num     = g1 ? 2'd2 : (g0 ? 2'd1 : 2'd0);
        o_push.data0   = x0;
        o_push.data1   = x1;
    end

endmodule

[design/escape_sequence_decoder_core.sv]
// ----------------------------------------------------------------------------
// escape_sequence_decoder_core
// Decodes C escape sequences in a byte stream, one source byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   signals                      direction
//  input     i_valid  o_stall  i_data     source characters in
//  result    o_valid  i_stall  o_data     decoded bytes out
//  config    i_cfg_we i_cfg_wdata         output limit write
//
// One source byte is taken per cycle while o_stall is low; its zero, one
// or two decoded bytes go into a four-entry result queue in the same edge
// and leave one per cycle while i_stall is low. Input stalls only while the
// queue holds more than two results, so a stream with one result per byte
// runs at one byte per cycle when i_stall stays low. Reset (synchronous)
// empties the queue, clears the parser state and sets the limit to 65535.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_core
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_esd_in     i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_esd_out    o_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    `include "escape_sequence_decoder_core_assert.svh"

    t_esd_state  r_state;
    t_esd_state  n_state;
    t_esd_push   push;
    logic [15:0] r_limit;
    t_esd_out    r_q [4];
    logic [1:0]  r_head;
    logic [1:0]  r_tail;
    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic        acc;
    logic        pop;
    logic [1:0]  push_num;

    // Parser next state
    esd_decode u_decode (
        .i_state (r_state),
        .i_item  (i_data),
        .i_limit (r_limit),
        .o_next  (n_state),
        .o_push  (push)
    );

    assign o_stall  = (r_count > 3'd2);
    assign acc      = i_valid && !o_stall;
    assign o_valid  = (r_count != 3'd0);
    assign pop      = o_valid && !i_stall;
    assign o_data   = r_q[r_head];
    assign push_num = acc ? push.num : 2'd0;
    assign n_count  = r_count + {1'b0, push_num} - {2'd0, pop};

    // Parser state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= MODE_PLAIN;
            r_state.accum   <= 9'd0;
            r_state.count   <= 2'd0;
            r_state.emitted <= 16'd0;
            r_limit         <= LIMIT_RESET;
        end else begin
            if (acc) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 2'd0;
            r_tail  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_head  <= r_head + {1'b0, pop};
            r_tail  <= r_tail + push_num;
            r_count <= n_count;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_q[r_tail].out_byte <= push.data0;
            r_q[r_tail].run_last <= (push_num == 2'd1);
        end
        if (push_num == 2'd2) begin
            r_q[r_tail + 2'd1].out_byte <= push.data1;
            r_q[r_tail + 2'd1].run_last <= 1'b1;
        end
    end

    // Checks
    `ESD_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'd4)
    `ESD_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, acc && i_data.is_end, r_state.emitted == 16'd0)
    `ESD_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && !acc, r_count == $past(r_count) - 3'd1)
    `ESD_ASSERT_NOW(a_done_silent, i_clk, i_rst_n, acc && r_state.mode == MODE_DONE, push.num == 2'd0)

endmodule

[tb/esd_result_checker.sv]
// ----------------------------------------------------------------------------
// esd_result_checker
// Watches the request, result and limit ports of the escape sequence decoder.
// It keeps its own copy of the parser state, predicts the decoded bytes of
// every accepted request, and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module esd_result_checker
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  t_esd_in     i_req_data,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  t_esd_out    i_res_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted parser state
    t_mode       mode;
    logic [8:0]  accum;
    logic [1:0]  digits;
    logic [15:0] emitted;
    logic [15:0] out_limit;

    // Bytes decoded from the current request
    logic [7:0]  step_bytes [2];
    int          step_count;

    t_esd_out    expected_bytes [$];
    t_esd_out    oldest;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_D0 && c <= CH_D9) return int'(c - CH_D0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    // Count a decoded byte against the limit; dropped once the limit is hit
    task automatic put_byte(input logic [7:0] b);
        if (emitted < out_limit) begin
            emitted = emitted + 16'd1;
            if (step_count < 2) begin
                step_bytes[step_count] = b;
                step_count++;
            end
        end
    endtask

    // Emit whatever escape is still open and go back to plain text
    task automatic flush_digits();
        case (mode)
            MODE_HEX0: put_byte(8'h00);
            MODE_HEX1, MODE_OCT: put_byte(accum[7:0]);
            default: ;
        endcase
        mode   = MODE_PLAIN;
        accum  = '0;
        digits = '0;
    endtask

    task automatic clear_string();
        mode    = MODE_PLAIN;
        accum   = '0;
        digits  = '0;
        emitted = '0;
    endtask

    task automatic take_text(input logic [7:0] c);
        if (c == CH_BSL) mode = MODE_ESC;
        else put_byte(c);
    endtask

    // Decode one source byte and queue the bytes it gives
    task automatic decode_request(input t_esd_in req);
        logic [7:0] c;
        int         h;
        c = req.in_char;
        h = hex_nibble(c);
        step_count = 0;
        if (mode == MODE_DONE) begin
            // after a NUL only the end flag matters
            if (req.is_end) clear_string();
        end else if (c == CH_NUL) begin
            flush_digits();
            if (req.is_end) clear_string();
            else mode = MODE_DONE;
        end else begin
            case (mode)
                MODE_ESC: begin
                    mode = MODE_PLAIN;
                    case (c)
                        CH_LA: put_byte(ESC_BEL);
                        CH_LB: put_byte(ESC_BS);
                        CH_LF: put_byte(ESC_FF);
                        CH_LN: put_byte(ESC_LF);
                        CH_LR: put_byte(ESC_CR);
                        CH_LT: put_byte(ESC_HT);
                        CH_LV: put_byte(ESC_VT);
                        // quote, backslash and question mark decode to themselves
                        CH_SQ, CH_DQ, CH_BSL, CH_QM: put_byte(c);
                        CH_X: begin
                            mode  = MODE_HEX0;
                            accum = '0;
                        end
                        default: begin
                            if (c >= CH_D0 && c <= CH_D7) begin
                                mode   = MODE_OCT;
                                accum  = 9'(c - CH_D0);
                                digits = 2'd1;
                            end else begin
                                put_byte(c);
                            end
                        end
                    endcase
                end
                MODE_HEX0: begin
                    if (h >= 0) begin
                        mode  = MODE_HEX1;
                        accum = 9'(h);
                    end else begin
                        flush_digits();
                        take_text(c);
                    end
                end
                MODE_HEX1: begin
                    if (h >= 0) begin
                        put_byte({accum[3:0], 4'(h)});
                        mode  = MODE_PLAIN;
                        accum = '0;
                    end else begin
                        flush_digits();
                        take_text(c);
                    end
                end
                MODE_OCT: begin
                    if (c >= CH_D0 && c <= CH_D7) begin
                        // nine bit accumulator, low byte kept on output
                        accum  = {accum[5:0], 3'b000} + 9'(c - CH_D0);
                        digits = digits + 2'd1;
                        if (digits == 2'd3 || digits == 2'd0) flush_digits();
                    end else begin
                        flush_digits();
                        take_text(c);
                    end
                end
                default: begin
                    mode = MODE_PLAIN;
                    take_text(c);
                end
            endcase
            if (req.is_end) begin
                flush_digits();
                clear_string();
            end
        end
        for (int k = 0; k < step_count; k++) begin
            expected_bytes.push_back(t_esd_out'{out_byte: step_bytes[k],
                                                run_last: (k == step_count - 1)});
        end
    endtask

    // Predict on accepted requests, then check accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_limit = LIMIT_RESET;
            clear_string();
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) out_limit = i_cfg_wdata;
            if (i_req_valid && !i_req_stall) decode_request(i_req_data);
            if (i_res_valid && !i_res_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("result with nothing expected: out_byte %02h run_last %0b",
                           i_res_data.out_byte, i_res_data.run_last);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (i_res_data.out_byte !== oldest.out_byte ||
                        i_res_data.run_last !== oldest.run_last) begin
                        if (i_res_data.out_byte !== oldest.out_byte)
                            $error("out_byte: expected %02h, got %02h",
                                   oldest.out_byte, i_res_data.out_byte);
                        if (i_res_data.run_last !== oldest.run_last)
                            $error("run_last: expected %0b, got %0b",
                                   oldest.run_last, i_res_data.run_last);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
        o_outstanding <= expected_bytes.size();
    end

endmodule

[tb/tb_escape_sequence_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder_core
// Drives source strings into the escape sequence decoder: a directed set of
// escapes and string ends, then random strings built from escapes, digit
// runs, NULs and noise, over several output limits and idle/stall mixes.
// The result checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;
    import esd_pkg::*;

    localparam int PHASE_REQS = 95;
    localparam int TAIL_CYCLES = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_esd_in     i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_esd_out    o_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;

    string simple_chars = "abfnrtv'\"\\?";
    string hex_chars    = "0123456789abcdefABCDEF";

    escape_sequence_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    esd_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_data    (i_data),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res_data    (o_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2ms;
        $display("[escape_sequence_decoder_core] ERROR");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one request, with random idle cycles first, until accepted
    task automatic send_req(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= t_esd_in'{in_char: c, is_end: last};
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic send_str(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++) send_req(s[i], end_last && i == s.len() - 1);
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic wait_drain();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random string of escapes and text; left open when close is clear
    task automatic send_rand_string(input bit close);
        logic [7:0] text [$];
        logic [7:0] c;
        int         kind;
        int         n;
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                do c = 8'($urandom_range(1, 255)); while (c == CH_BSL);
                text.push_back(c);
            end else if (kind < 45) begin
                text.push_back(CH_BSL);
                text.push_back(simple_chars[$urandom_range(simple_chars.len() - 1)]);
            end else if (kind < 60) begin
                text.push_back(CH_BSL);
                text.push_back(CH_X);
                n = $urandom_range(2);
                repeat (n) text.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
            end else if (kind < 75) begin
                text.push_back(CH_BSL);
                n = $urandom_range(1, 3);
                repeat (n) text.push_back(CH_D0 + 8'($urandom_range(7)));
            end else if (kind < 83) begin
                // escape of an arbitrary byte
                text.push_back(CH_BSL);
                text.push_back(8'($urandom_range(1, 255)));
            end else if (kind < 88) begin
                // NUL inside the string, trailing bytes ignored
                text.push_back(CH_NUL);
                repeat ($urandom_range(3)) text.push_back(8'($urandom_range(255)));
            end else if (kind < 93) begin
                text.push_back(CH_BSL);
            end else begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(9) == 0) text.push_back(CH_NUL);
        foreach (text[i]) send_req(text[i], close && i == text.size() - 1);
    endtask

    // Stimulus and verdict
    initial begin
        int          idle_sel  [5];
        int          stall_sel [5];
        logic [15:0] limit_sel [5];
        int          target;

        idle_sel  = '{0, 72, 0, 33, 0};
        stall_sel = '{0, 0, 72, 33, 0};
        limit_sel = '{LIMIT_RESET, 16'd0, 16'd1, 16'($urandom_range(2, 12)),
                      16'($urandom_range(65535))};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: simple, hex, octal overflow, broken digit run, unknown escape
        send_str("A\\n\\x41\\xg\\777\\18\\q", 1'b0);
        send_req(CH_BSL, 1'b0);
        send_req(8'hFF, 1'b0);
        // lone backslash at the end, then an empty hex escape at the end
        send_str("\\", 1'b1);
        send_str("\\x", 1'b1);
        // NUL ends the string; '0' and the rest wait for the end flag
        send_str("B", 1'b0);
        send_req(CH_NUL, 1'b0);
        send_str("0", 1'b0);
        send_req(8'hFF, 1'b1);
        send_req(CH_NUL, 1'b1);
        wait_drain();

        // Random phases; each ends mid string so the new limit lands mid string
        for (int p = 0; p < 5; p++) begin
            write_limit(limit_sel[p]);
            idle_pct  = idle_sel[p];
            stall_pct = stall_sel[p];
            target    = sent + PHASE_REQS;
            while (sent < target) send_rand_string(1'b1);
            send_rand_string(1'b0);
            wait_drain();
        end
        stall_pct = 0;
        wait_drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("[escape_sequence_decoder_core] OK");
        end else begin
            $display("[escape_sequence_decoder_core] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/esd_pkg.sv
design/esd_decode.sv
design/escape_sequence_decoder_core.sv
tb/esd_result_checker.sv
tb/tb_escape_sequence_decoder_core.sv
